/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define SLCD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked from the cycle of the trigger onward.
`define SLCD_ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the trigger.
`define SLCD_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/slcd_pkg.sv */
// Types and constants shared by the sync, length and checksum deframer.
package slcd_pkg;

  // Parser phase of the frame currently being received.
  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_BID  = 3'd1,
    PH_MID  = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_SUM  = 3'd5
  } phase_t;

  // Event code reported with every result beat.
  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_GOOD    = 3'd2,
    EV_CKBAD   = 3'd3,
    EV_LENBAD  = 3'd4,
    EV_SYNCBAD = 3'd5
  } event_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_START_BYTE  = 2'd0;
  localparam logic [1:0] REG_BUS_ID_BYTE = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [7:0] START_BYTE_RST  = 8'd250;
  localparam logic [7:0] BUS_ID_BYTE_RST = 8'd255;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd254;

  // Configuration seen by the parser.
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] bus_id_byte;
    logic [7:0] max_payload;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    event_t     event_kind;
    logic [7:0] message_id;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
  } result_t;

endpackage

/* hdl/sync_length_checksum_deframer.sv */
// Top level of the byte-serial frame deframer with configuration registers.
// The deframer takes one received byte per beat and returns exactly one result beat for
// it in the cycle after it is accepted, at a sustained rate of one byte per clock cycle
// while the result side does not stall. Each byte passes through the parser's compare and
// 8-bit sum logic into a single output register; a new byte is accepted whenever that
// register is empty or is being drained in the same cycle, so stalls on the result side
// hold the input side for as long as they last. Frames are a start byte, the bus-id byte,
// a message id, a length, the payload bytes and a checksum byte; payload bytes stream out
// with their index and the frame ends in a good, checksum bad, length bad or sync bad
// event. Configuration writes are taken in any cycle and should only be issued while no byte is in flight.
module sync_length_checksum_deframer
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write channel.
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Received byte channel.
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  // Result channel.
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_message_id,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_payload_index,
  output logic [7:0] out_frame_length
);

  cfg_t    cfg_r;
  result_t step_result;
  result_t out_r;
  logic    out_valid_r;
  logic    in_fire;

  // Configuration registers, written one beat at a time.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= START_BYTE_RST;
      cfg_r.bus_id_byte <= BUS_ID_BYTE_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_BYTE:  cfg_r.start_byte  <= cfg_data;
        REG_BUS_ID_BYTE: cfg_r.bus_id_byte <= cfg_data;
        REG_MAX_PAYLOAD: cfg_r.max_payload <= cfg_data;
        default: ;
      endcase
    end
  end

  // A byte enters when the output register is free or drains this cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  slcd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .result  (step_result)
  );

  // Output register holding one result beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_r <= step_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_r.event_kind;
  assign out_message_id    = out_r.message_id;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;
  assign out_frame_length  = out_r.frame_length;

endmodule

/* hdl/slcd_parser.sv */
// Frame parser: holds the frame state and forms the result for each byte.
module slcd_parser
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output result_t    result
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] id_r, id_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_add;
  logic [7:0] count_inc;

  // State registers advance once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      sum_r   <= 8'd0;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      count_r <= 8'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
    end
  end

  assign sum_add   = sum_r + rx_byte;
  assign count_inc = count_r + 8'd1;

  // Next state and the result beat for the current byte.
  always_comb begin
    phase_nxt            = phase_r;
    sum_nxt              = sum_add;
    id_nxt               = id_r;
    len_nxt              = len_r;
    count_nxt            = count_r;
    result.event_kind    = EV_IDLE;
    result.payload_byte  = 8'd0;
    result.payload_index = 8'd0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.start_byte) begin
          phase_nxt = PH_BID;
          sum_nxt   = 8'd0;
        end
      end
      PH_BID: begin
        if (rx_byte == cfg.bus_id_byte) begin
          phase_nxt = PH_MID;
        end else begin
          result.event_kind = EV_SYNCBAD;
          phase_nxt         = PH_HUNT;
        end
      end
      PH_MID: begin
        id_nxt    = rx_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = rx_byte;
        if (rx_byte > cfg.max_payload) begin
          result.event_kind = EV_LENBAD;
          phase_nxt         = PH_HUNT;
        end else begin
          count_nxt = 8'd0;
          phase_nxt = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        result.event_kind    = EV_DATA;
        result.payload_byte  = rx_byte;
        result.payload_index = count_r;
        count_nxt            = count_inc;
        if (count_inc >= len_r) begin
          phase_nxt = PH_SUM;
        end
      end
      PH_SUM: begin
        result.event_kind = (sum_add == 8'd0) ? EV_GOOD : EV_CKBAD;
        phase_nxt         = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
    result.message_id   = id_nxt;
    result.frame_length = len_nxt;
  end

endmodule

/* hdl/slcd_checker.sv */
// Port-level assertion checker for the deframer, bound to the top level.
`include "assert_macros.svh"

module slcd_checker
  import slcd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_event_kind,
  input logic [7:0] out_payload_byte,
  input logic [7:0] out_payload_index
);

  // Every accepted byte yields a result beat in the following cycle.
  `SLCD_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, in_valid && in_ready, out_valid, "accepted beat produced no result")

  // The input side is never held off while the output register is empty.
  `SLCD_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

  // A stalled result beat keeps its payload.
  `SLCD_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_event_kind) && $stable(out_payload_byte), "stalled result changed")

  // Payload fields are zero on every event other than a payload byte.
  `SLCD_ASSERT_IMPL(a_payload_zero, clk, rst_n, out_valid && (out_event_kind != EV_DATA), (out_payload_byte == 8'd0) && (out_payload_index == 8'd0), "payload fields set outside payload event")

endmodule

bind sync_length_checksum_deframer slcd_checker u_slcd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_event_kind    (out_event_kind),
  .out_payload_byte  (out_payload_byte),
  .out_payload_index (out_payload_index)
);

/* verif/slcd_result_check.sv */
// Result checker of the deframer: predicts every result beat and compares it with the block.
module slcd_result_check
  import slcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_event_kind,
  input  logic [7:0] out_message_id,
  input  logic [7:0] out_payload_byte,
  input  logic [7:0] out_payload_index,
  input  logic [7:0] out_frame_length,
  output int         mismatch_count,
  output int         events_pending
);

  // Our own copy of the configuration and of the parser state.
  cfg_t       cfg_copy;
  phase_t     parse_phase;
  logic [7:0] frame_sum;
  logic [7:0] frame_id;
  logic [7:0] frame_len;
  logic [7:0] payload_count;

  // Events predicted for accepted bytes, oldest first.
  result_t predicted_events[$];
  int      errors_seen;

  initial begin
    mismatch_count = 0;
    events_pending = 0;
    errors_seen = 0;
  end

  // Advance the parser by one received byte and work out the event it causes.
  task automatic parse_rx_byte(input logic [7:0] rx, output result_t ev);
    ev = '0;
    ev.event_kind = EV_IDLE;
    frame_sum = frame_sum + rx;
    case (parse_phase)
      PH_HUNT: begin
        if (rx == cfg_copy.start_byte) begin
          parse_phase = PH_BID;
          frame_sum = 8'd0;
        end
      end
      PH_BID: begin
        if (rx == cfg_copy.bus_id_byte) begin
          parse_phase = PH_MID;
        end else begin
          ev.event_kind = EV_SYNCBAD;
          parse_phase = PH_HUNT;
        end
      end
      PH_MID: begin
        frame_id = rx;
        parse_phase = PH_LEN;
      end
      PH_LEN: begin
        frame_len = rx;
        if (rx > cfg_copy.max_payload) begin
          ev.event_kind = EV_LENBAD;
          parse_phase = PH_HUNT;
        end else begin
          payload_count = 8'd0;
          parse_phase = (rx == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        ev.event_kind = EV_DATA;
        ev.payload_byte = rx;
        ev.payload_index = payload_count;
        payload_count = payload_count + 8'd1;
        if (payload_count >= frame_len) begin
          parse_phase = PH_SUM;
        end
      end
      PH_SUM: begin
        // The sum from bus id through checksum must come out to zero.
        ev.event_kind = (frame_sum == 8'd0) ? EV_GOOD : EV_CKBAD;
        parse_phase = PH_HUNT;
      end
      default: begin
        parse_phase = PH_HUNT;
      end
    endcase
    ev.message_id = frame_id;
    ev.frame_length = frame_len;
  endtask

  // Watch all three channels at each clock edge.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    result_t next_ev;
    if (!rst_n) begin
      cfg_copy.start_byte = START_BYTE_RST;
      cfg_copy.bus_id_byte = BUS_ID_BYTE_RST;
      cfg_copy.max_payload = MAX_PAYLOAD_RST;
      parse_phase = PH_HUNT;
      frame_sum = 8'd0;
      frame_id = 8'd0;
      frame_len = 8'd0;
      payload_count = 8'd0;
      predicted_events.delete();
    end else begin
      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_BYTE:  cfg_copy.start_byte = cfg_data;
          REG_BUS_ID_BYTE: cfg_copy.bus_id_byte = cfg_data;
          REG_MAX_PAYLOAD: cfg_copy.max_payload = cfg_data;
          default: ;
        endcase
      end

      // A result beat is checked against the oldest prediction.
      if (out_valid && out_ready) begin
        got.event_kind = event_t'(out_event_kind);
        got.message_id = out_message_id;
        got.payload_byte = out_payload_byte;
        got.payload_index = out_payload_index;
        got.frame_length = out_frame_length;
        if (predicted_events.size() == 0) begin
          if (errors_seen < 10) begin
            $display("Unexpected result beat at %0t: kind %0d id %0h byte %0h index %0d len %0d",
                     $time, got.event_kind, got.message_id, got.payload_byte,
                     got.payload_index, got.frame_length);
          end
          errors_seen++;
        end else begin
          want = predicted_events.pop_front();
          if (got.event_kind !== want.event_kind || got.message_id !== want.message_id ||
              got.payload_byte !== want.payload_byte ||
              got.payload_index !== want.payload_index ||
              got.frame_length !== want.frame_length) begin
            if (errors_seen < 10) begin
              $display("Mismatch at %0t: expected kind %0d id %0h byte %0h index %0d len %0d",
                       $time, want.event_kind, want.message_id, want.payload_byte,
                       want.payload_index, want.frame_length);
              $display("                  got kind %0d id %0h byte %0h index %0d len %0d",
                       got.event_kind, got.message_id, got.payload_byte,
                       got.payload_index, got.frame_length);
            end
            errors_seen++;
          end
        end
      end

      // Every accepted byte causes exactly one result beat.
      if (in_valid && in_ready) begin
        parse_rx_byte(in_rx_byte, next_ev);
        predicted_events.push_back(next_ev);
      end
    end
    mismatch_count <= errors_seen;
    events_pending <= predicted_events.size();
  end

endmodule

/* verif/sync_length_checksum_deframer_tb.sv */
// Testbench top of the deframer: drives frames, noise and register writes and gives the verdict.
module sync_length_checksum_deframer_tb;
  import slcd_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_START_BYTE;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_kind;
  logic [7:0] out_message_id;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_frame_length;

  int mismatch_count;
  int events_pending;

  // Stimulus-side view of the registers, used to build frames.
  logic [7:0] cur_start = START_BYTE_RST;
  logic [7:0] cur_bus = BUS_ID_BYTE_RST;
  logic [7:0] cur_max = MAX_PAYLOAD_RST;

  int send_gap_pct = 33;
  int recv_stall_pct = 59;
  int bytes_sent = 0;

  sync_length_checksum_deframer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_message_id    (out_message_id),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length)
  );

  slcd_result_check result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_message_id    (out_message_id),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_frame_length  (out_frame_length),
    .mismatch_count    (mismatch_count),
    .events_pending    (events_pending)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random in the current proportion.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Send one byte beat, after a random gap, and wait until it is taken.
  task automatic send_byte(input logic [7:0] rx, input bit counted);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= rx;
    do @(posedge clk); while (!in_ready);
    if (counted) begin
      bytes_sent++;
    end
  endtask

  // Stop sending and wait until every predicted result beat has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all three registers back to back; the block must be idle.
  task automatic set_config(input logic [7:0] start_val, input logic [7:0] bus_val,
                            input logic [7:0] max_val);
    write_reg(REG_START_BYTE, start_val);
    write_reg(REG_BUS_ID_BYTE, bus_val);
    write_reg(REG_MAX_PAYLOAD, max_val);
    cfg_valid <= 1'b0;
    cur_start = start_val;
    cur_bus = bus_val;
    cur_max = max_val;
  endtask

  // Send a frame with the given id and length. A length over the limit ends the frame
  // after the length byte. The checksum can be spoiled on purpose.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input bit bad_sum,
                            input bit extremes);
    logic [7:0] sum;
    logic [7:0] data;
    send_byte(cur_start, 1'b1);
    send_byte(cur_bus, 1'b1);
    send_byte(id, 1'b1);
    send_byte(len, 1'b1);
    sum = cur_bus + id + len;
    if (len <= cur_max) begin
      for (int i = 0; i < len; i++) begin
        data = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
        send_byte(data, 1'b1);
        sum = sum + data;
      end
      data = -sum;
      if (bad_sum) begin
        data = data ^ (8'd1 << $urandom_range(0, 7));
      end
      send_byte(data, 1'b1);
    end
  endtask

  // Mostly well-formed frames with random content, with noise and broken frames mixed in.
  task automatic run_random(input int target);
    int pick;
    int max_i;
    int len_i;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      max_i = cur_max;
      if (pick < 72) begin
        len_i = $urandom_range(0, 99);
        if (len_i < 2) begin
          len_i = max_i;
        end else if (len_i < 10 && max_i < 255) begin
          len_i = $urandom_range(max_i + 1, 255);
        end else begin
          len_i = $urandom_range(0, (max_i < 8) ? max_i : 8);
        end
        send_frame(8'($urandom_range(0, 255)), 8'(len_i), ($urandom_range(0, 9) == 0), 1'b0);
      end else if (pick < 85) begin
        // Line noise between frames.
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 93) begin
        // Start byte followed by an arbitrary byte, usually a wrong bus id.
        send_byte(cur_start, 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // Header cut short; whatever follows is taken as the rest of this frame.
        send_byte(cur_start, 1'b1);
        send_byte(cur_bus, 1'b1);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames under the reset register values.
    send_byte(8'h00, 1'b0);
    send_frame(8'hA5, 8'd2, 1'b0, 1'b1);
    send_frame(8'h5A, 8'd0, 1'b0, 1'b0);
    send_frame(8'h00, 8'd2, 1'b1, 1'b1);
    send_byte(cur_start, 1'b1);
    send_byte(~cur_bus, 1'b1);
    send_frame(8'hFF, 8'hFF, 1'b0, 1'b0);
    run_random(260);

    // Lowest register values: only zero-length frames are accepted.
    drain_results();
    set_config(8'h00, 8'h00, 8'h00);
    run_random(520);

    // Highest start byte and length limit, with the idle pattern swapped.
    drain_results();
    send_gap_pct = 59;
    recv_stall_pct <= 33;
    set_config(8'hFF, 8'hAA, 8'hFF);
    run_random(790);

    // Random bytes and a small limit, at full rate.
    drain_results();
    send_gap_pct = 0;
    recv_stall_pct <= 0;
    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(1, 16)));
    run_random(1050);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
